// ===== src/cbpg_pkg.sv =====
package cbpg_pkg;

  // Field widths
  localparam int COORD_WIDTH = 16;
  localparam int SEG_W       = 6;
  localparam logic [SEG_W-1:0] MAX_SEGMENTS = SEG_W'(63);

  // Curve parameter t in Q0.16, one extra bit so that 1.0 fits
  localparam int T_W = 17;
  localparam logic [T_W-1:0] T_ONE = {1'b1, {(T_W-1){1'b0}}};

  // Bernstein weights: products of three Q0.16 values, Q0.48 with 1.0 included
  localparam int SQ_W    = 2 * T_W - 1;
  localparam int MUL_P_W = SQ_W + T_W;
  localparam int W_FRAC  = 3 * (T_W - 1);
  localparam int W_W     = W_FRAC + 1;

  // Weight x coordinate is done in two halves of the weight
  localparam int LO_W   = W_W / 2;
  localparam int PART_W = W_W - LO_W + 1;
  localparam int PROD_W = PART_W + COORD_WIDTH;
  localparam int ACC_W  = W_W + COORD_WIDTH;
  localparam logic [ACC_W-1:0] ACC_BIAS =
    {{(ACC_W-W_FRAC){1'b0}}, 1'b1, {(W_FRAC-1){1'b0}}};

  // Sequencer step counts
  localparam int STEP_W    = 5;
  localparam int DIV_STEPS = T_W;
  localparam int WGT_STEPS = 7;
  localparam int MAC_STEPS = 9;
  localparam int DIV_SPAN  = DIV_STEPS + 1;
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] WGT_LAST = STEP_W'(WGT_STEPS - 1);
  localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(MAC_STEPS - 1);
  localparam logic [STEP_W-1:0] STEP_ZERO = '0;

  // Weight step codes, issued in this order
  localparam logic [2:0] WS_UU = 3'd0;
  localparam logic [2:0] WS_TU = 3'd1;
  localparam logic [2:0] WS_TT = 3'd2;
  localparam logic [2:0] WS_W0 = 3'd3;
  localparam logic [2:0] WS_W1 = 3'd4;
  localparam logic [2:0] WS_W2 = 3'd5;
  localparam logic [2:0] WS_W3 = 3'd6;

  typedef logic [3:0][2:0][COORD_WIDTH-1:0] pts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WGT,
    ST_MAC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       wgt_step;
    logic       acc_init;
    logic       mac_mul;
    logic       mac_add;
    logic       emit;
    logic       advance;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } sts_t;

endpackage

// ===== src/cbpg_ifs.sv =====
interface cbpg_in_if;
  logic valid;
  logic ready;
  logic signed [cbpg_pkg::COORD_WIDTH-1:0] p0_x, p0_y, p0_z;
  logic signed [cbpg_pkg::COORD_WIDTH-1:0] p1_x, p1_y, p1_z;
  logic signed [cbpg_pkg::COORD_WIDTH-1:0] p2_x, p2_y, p2_z;
  logic signed [cbpg_pkg::COORD_WIDTH-1:0] p3_x, p3_y, p3_z;

  modport source (
    output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
           p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
           p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    output ready
  );
endinterface

interface cbpg_out_if;
  logic valid;
  logic ready;
  logic signed [cbpg_pkg::COORD_WIDTH-1:0] curve_x, curve_y, curve_z;
  logic is_last;

  modport source (
    output valid, curve_x, curve_y, curve_z, is_last,
    input  ready
  );
  modport sink (
    input  valid, curve_x, curve_y, curve_z, is_last,
    output ready
  );
endinterface

// ===== src/cbpg_ctrl.sv =====
module cbpg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cbpg_pkg::sts_t  sts_i,
  output cbpg_pkg::cmd_t  cmd_o
);

  cbpg_pkg::state_e state_q, state_d;
  logic [cbpg_pkg::STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbpg_pkg::ST_IDLE;
      step_q  <= cbpg_pkg::STEP_ZERO;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and step count
  always_comb begin
    state_d = state_q;
    step_d  = step_q + cbpg_pkg::STEP_W'(1);
    case (state_q)
      cbpg_pkg::ST_IDLE: begin
        step_d = cbpg_pkg::STEP_ZERO;
        if (in_valid_i) begin
          state_d = cbpg_pkg::ST_DIV;
        end
      end
      cbpg_pkg::ST_DIV: begin
        if (step_q == cbpg_pkg::DIV_LAST) begin
          state_d = cbpg_pkg::ST_WGT;
          step_d  = cbpg_pkg::STEP_ZERO;
        end
      end
      cbpg_pkg::ST_WGT: begin
        if (step_q == cbpg_pkg::WGT_LAST) begin
          state_d = cbpg_pkg::ST_MAC;
          step_d  = cbpg_pkg::STEP_ZERO;
        end
      end
      cbpg_pkg::ST_MAC: begin
        if (step_q == cbpg_pkg::MAC_LAST) begin
          state_d = cbpg_pkg::ST_EMIT;
          step_d  = cbpg_pkg::STEP_ZERO;
        end
      end
      cbpg_pkg::ST_EMIT: begin
        step_d = cbpg_pkg::STEP_ZERO;
        if (sts_i.out_free) begin
          state_d = sts_i.last ? cbpg_pkg::ST_IDLE : cbpg_pkg::ST_WGT;
        end
      end
      default: begin
        state_d = cbpg_pkg::ST_IDLE;
        step_d  = cbpg_pkg::STEP_ZERO;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cbpg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      cbpg_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      cbpg_pkg::ST_WGT: begin
        // weight step codes follow the step count
        cmd_o.wgt_step = 1'b1;
        cmd_o.sel      = step_q[2:0];
        cmd_o.acc_init = (step_q == cbpg_pkg::WGT_LAST);
      end
      cbpg_pkg::ST_MAC: begin
        // multiply term (step), add the term of the step before
        cmd_o.sel     = step_q[2:0];
        cmd_o.mac_mul = (step_q != cbpg_pkg::MAC_LAST);
        cmd_o.mac_add = (step_q != cbpg_pkg::STEP_ZERO);
      end
      cbpg_pkg::ST_EMIT: begin
        cmd_o.emit    = sts_i.out_free;
        cmd_o.advance = sts_i.out_free && !sts_i.last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_div_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbpg_pkg::ST_IDLE && in_valid_i)
      |-> ##(cbpg_pkg::DIV_SPAN) (state_q == cbpg_pkg::ST_WGT))
    else $error("divider phase has wrong length");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbpg_pkg::ST_EMIT && !sts_i.out_free) |=> (state_q == cbpg_pkg::ST_EMIT))
    else $error("point dropped while output is blocked");

endmodule

// ===== src/cbpg_datapath.sv =====
module cbpg_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cbpg_pkg::cmd_t                         cmd_i,
  output cbpg_pkg::sts_t                         sts_o,
  input  logic [cbpg_pkg::SEG_W-1:0]             seg_count_i,
  input  cbpg_pkg::pts_t                         pts_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [cbpg_pkg::COORD_WIDTH-1:0] curve_x_o,
  output logic signed [cbpg_pkg::COORD_WIDTH-1:0] curve_y_o,
  output logic signed [cbpg_pkg::COORD_WIDTH-1:0] curve_z_o,
  output logic                                   is_last_o
);

  localparam int SEG_W = cbpg_pkg::SEG_W;
  localparam int T_W   = cbpg_pkg::T_W;
  localparam int CW    = cbpg_pkg::COORD_WIDTH;

  // Control state
  logic [SEG_W-1:0] n_q, i_q, r_q;
  logic [T_W-1:0]   t_q;
  logic             out_valid_q, prod_hi_q;

  // Payload state
  cbpg_pkg::pts_t                         pts_q;
  logic [T_W-1:0]                         dvd_q, quo_q;
  logic [SEG_W-1:0]                       rem_q;
  logic [cbpg_pkg::SQ_W-1:0]              uu_q, tu_q, tt_q;
  logic [3:0][cbpg_pkg::W_W-1:0]          w_q;
  logic signed [CW-1:0]                   out_x_q, out_y_q, out_z_q;
  logic                                   out_last_q;

  logic [SEG_W-1:0] n_eff;
  logic [T_W-1:0]   u;
  logic [SEG_W:0]   rem2, rem_sub, r_sum, r_sub;
  logic             ge, wrap;
  logic [SEG_W-1:0] rem_d, r_d;
  logic [T_W-1:0]   t_d;

  logic [cbpg_pkg::SQ_W-1:0]    mul_a;
  logic [T_W-1:0]               mul_b;
  logic [cbpg_pkg::MUL_P_W-1:0] mul_p, mul3;

  logic [1:0]                 mac_k;
  logic                       mac_hi;
  logic [cbpg_pkg::W_W-1:0]   w_sel;
  logic [2:0][CW-1:0]         res_c;

  // Clamp the segment count into its legal range
  always_comb begin
    if (seg_count_i == '0) begin
      n_eff = SEG_W'(1);
    end else if (seg_count_i > cbpg_pkg::MAX_SEGMENTS) begin
      n_eff = cbpg_pkg::MAX_SEGMENTS;
    end else begin
      n_eff = seg_count_i;
    end
  end

  assign u = cbpg_pkg::T_ONE - t_q;

  // Restoring divider for 1.0 / n, one quotient bit per step
  assign rem2    = {rem_q, dvd_q[T_W-1]};
  assign ge      = rem2 >= {1'b0, n_q};
  assign rem_sub = rem2 - {1'b0, n_q};
  assign rem_d   = ge ? rem_sub[SEG_W-1:0] : rem2[SEG_W-1:0];

  // Step t by quotient plus carried remainder
  assign r_sum = {1'b0, r_q} + {1'b0, rem_q};
  assign wrap  = r_sum >= {1'b0, n_q};
  assign r_sub = r_sum - {1'b0, n_q};
  assign r_d   = wrap ? r_sub[SEG_W-1:0] : r_sum[SEG_W-1:0];
  assign t_d   = t_q + quo_q + T_W'(wrap);

  // Shared weight multiplier
  always_comb begin
    case (cmd_i.sel)
      cbpg_pkg::WS_UU: begin mul_a = cbpg_pkg::SQ_W'(u);   mul_b = u;   end
      cbpg_pkg::WS_TU: begin mul_a = cbpg_pkg::SQ_W'(t_q); mul_b = u;   end
      cbpg_pkg::WS_TT: begin mul_a = cbpg_pkg::SQ_W'(t_q); mul_b = t_q; end
      cbpg_pkg::WS_W0: begin mul_a = uu_q;                 mul_b = u;   end
      cbpg_pkg::WS_W1: begin mul_a = tu_q;                 mul_b = u;   end
      cbpg_pkg::WS_W2: begin mul_a = tu_q;                 mul_b = t_q; end
      cbpg_pkg::WS_W3: begin mul_a = tt_q;                 mul_b = t_q; end
      default:         begin mul_a = '0;                   mul_b = '0;  end
    endcase
  end

  assign mul_p = cbpg_pkg::MUL_P_W'(mul_a) * cbpg_pkg::MUL_P_W'(mul_b);
  assign mul3  = mul_p + {mul_p[cbpg_pkg::MUL_P_W-2:0], 1'b0};

  assign mac_k  = cmd_i.sel[2:1];
  assign mac_hi = cmd_i.sel[0];
  assign w_sel  = w_q[mac_k];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= SEG_W'(1);
      i_q         <= '0;
      r_q         <= '0;
      t_q         <= '0;
      out_valid_q <= 1'b0;
      prod_hi_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        n_q <= n_eff;
        i_q <= '0;
        r_q <= '0;
        t_q <= '0;
      end else if (cmd_i.advance) begin
        i_q <= i_q + SEG_W'(1);
        r_q <= r_d;
        t_q <= t_d;
      end
      if (cmd_i.mac_mul) begin
        prod_hi_q <= mac_hi;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pts_q <= pts_i;
      dvd_q <= cbpg_pkg::T_ONE;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[T_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[T_W-2:0], ge};
    end
    if (cmd_i.wgt_step) begin
      case (cmd_i.sel)
        cbpg_pkg::WS_UU: uu_q   <= mul_p[cbpg_pkg::SQ_W-1:0];
        cbpg_pkg::WS_TU: tu_q   <= mul_p[cbpg_pkg::SQ_W-1:0];
        cbpg_pkg::WS_TT: tt_q   <= mul_p[cbpg_pkg::SQ_W-1:0];
        cbpg_pkg::WS_W0: w_q[0] <= mul_p[cbpg_pkg::W_W-1:0];
        cbpg_pkg::WS_W1: w_q[1] <= mul3[cbpg_pkg::W_W-1:0];
        cbpg_pkg::WS_W2: w_q[2] <= mul3[cbpg_pkg::W_W-1:0];
        cbpg_pkg::WS_W3: w_q[3] <= mul_p[cbpg_pkg::W_W-1:0];
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      out_x_q    <= $signed(res_c[0]);
      out_y_q    <= $signed(res_c[1]);
      out_z_q    <= $signed(res_c[2]);
      out_last_q <= sts_o.last;
    end
  end

  // One multiply-accumulate lane per axis
  for (genvar ln = 0; ln < 3; ln++) begin : g_lane
    logic signed [cbpg_pkg::PART_W-1:0] wpart;
    logic signed [CW-1:0]               coord;
    logic signed [cbpg_pkg::PROD_W-1:0] prod_q;
    logic signed [cbpg_pkg::ACC_W-1:0]  acc_q;
    logic [cbpg_pkg::ACC_W-1:0]         prod_ext, addend;

    assign coord = $signed(pts_q[mac_k][ln]);
    assign wpart = mac_hi
      ? $signed({1'b0, w_sel[cbpg_pkg::W_W-1:cbpg_pkg::LO_W]})
      : $signed({{(cbpg_pkg::PART_W-cbpg_pkg::LO_W){1'b0}}, w_sel[cbpg_pkg::LO_W-1:0]});

    assign prod_ext = {{(cbpg_pkg::ACC_W-cbpg_pkg::PROD_W){prod_q[cbpg_pkg::PROD_W-1]}},
                       prod_q};
    assign addend   = prod_hi_q ? (prod_ext << cbpg_pkg::LO_W) : prod_ext;

    always_ff @(posedge clk_i) begin
      if (cmd_i.mac_mul) begin
        prod_q <= wpart * coord;
      end
      if (cmd_i.acc_init) begin
        acc_q <= $signed(cbpg_pkg::ACC_BIAS);
      end else if (cmd_i.mac_add) begin
        acc_q <= acc_q + $signed(addend);
      end
    end

    assign res_c[ln] = acc_q[cbpg_pkg::W_FRAC+CW-1:cbpg_pkg::W_FRAC];
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last     = (i_q == n_q);

  assign out_valid_o = out_valid_q;
  assign curve_x_o   = out_x_q;
  assign curve_y_o   = out_y_q;
  assign curve_z_o   = out_z_q;
  assign is_last_o   = out_last_q;

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted point not presented");

  a_last_t_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.last |-> (t_q == cbpg_pkg::T_ONE))
    else $error("t does not reach 1.0 on the last point");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_q < n_q)
    else $error("t remainder out of range");

endmodule

// ===== src/cubic_bezier_point_generator_top.sv =====
// Flow: one request is taken at a time; a new request is accepted only
//   once the last point of the current one has been emitted. Points are
//   computed with the shared weight multiplier and the three
//   multiply-accumulate lanes; output stalls hold the sequence back.
// Reset: asynchronous, active low; segment count returns to 63, the
//   sequencer to idle and the output register to empty.
module cubic_bezier_point_generator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cbpg_pkg::SEG_W-1:0] cfg_wdata_i,
  cbpg_in_if.sink                    in_req,
  cbpg_out_if.source                 out_res
);

  // Segment count register. Write it only while the block is idle; the block itself does not enforce this.
  logic [cbpg_pkg::SEG_W-1:0] seg_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= cbpg_pkg::MAX_SEGMENTS;
    end else if (cfg_we_i) begin
      seg_count_q <= cfg_wdata_i;
    end
  end

  // Gather the control points, P0..P3 by x, y, z.
  cbpg_pkg::pts_t pts;

  assign pts[0][0] = in_req.p0_x;
  assign pts[0][1] = in_req.p0_y;
  assign pts[0][2] = in_req.p0_z;
  assign pts[1][0] = in_req.p1_x;
  assign pts[1][1] = in_req.p1_y;
  assign pts[1][2] = in_req.p1_z;
  assign pts[2][0] = in_req.p2_x;
  assign pts[2][1] = in_req.p2_y;
  assign pts[2][2] = in_req.p2_z;
  assign pts[3][0] = in_req.p3_x;
  assign pts[3][1] = in_req.p3_y;
  assign pts[3][2] = in_req.p3_z;

  cbpg_pkg::cmd_t cmd;
  cbpg_pkg::sts_t sts;

  // Sequencer: accept a request, run the 17-step 1.0/n division, then for
  // each point run 7 weight steps, 9 accumulate steps and one emit step.
  // The emit step waits only until the output register is free, so the
  // next point is computed while the previous one waits to be taken.
  cbpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_req.valid),
    .in_ready_o (in_req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: t advances by the stored quotient and remainder, weights
  // u^3, 3tu^2, 3t^2u, t^3 come from one multiplier, and each axis lane
  // sums weight x coordinate in two halves with a round-to-nearest bias.
  cbpg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seg_count_i (seg_count_q),
    .pts_i       (pts),
    .out_valid_o (out_res.valid),
    .out_ready_i (out_res.ready),
    .curve_x_o   (out_res.curve_x),
    .curve_y_o   (out_res.curve_y),
    .curve_z_o   (out_res.curve_z),
    .is_last_o   (out_res.is_last)
  );

endmodule
